>>> rtl/core/assert_macros.svh
// assertion macros shared by the modbus rtu read transaction rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MRT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("modbus rtu read transaction: assertion failed");

// condition must never be true outside reset
`define MRT_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("modbus rtu read transaction: forbidden condition seen");

`endif

>>> rtl/core/mrt_pkg.sv
// types, constants and crc function of the modbus rtu read transaction
package mrt_pkg;

  // input opcodes
  localparam logic [1:0] OP_SEND_REQ = 2'd0;
  localparam logic [1:0] OP_RX_BYTE  = 2'd1;
  localparam logic [1:0] OP_SILENCE  = 2'd2;

  // result kinds
  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // verdict codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TIMEOUT   = 2'd1,
    STATUS_FRAME_ERR = 2'd2,
    STATUS_EXCEPTION = 2'd3
  } status_e;

  // protocol constants
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] READ_COUNT        = 16'h0001;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam int unsigned EXC_BIT           = 7;
  // address, function, length byte and two crc bytes around the data
  localparam logic [9:0]  FRAME_OVERHEAD    = 10'd5;
  localparam int unsigned REQ_BYTES         = 8;
  localparam int unsigned REQ_CRC_POS       = 6;

  // one input transaction
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  dev_addr;
    logic [15:0] reg_addr;
    logic [7:0]  rx_byte;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [1:0]  status;
    logic [15:0] reg_value;
    logic        last;
  } out_item_t;

  // request from the frame controller to the output serializer
  typedef struct packed {
    logic        req;
    logic        verdict;
    logic [7:0]  dev_addr;
    logic [15:0] reg_addr;
    status_e     status;
    logic [15:0] reg_value;
  } tx_load_t;

  // modbus crc-16 update by one byte, reflected polynomial
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

>>> rtl/core/mrt_frame_ctrl.sv
// frame controller: request start, reply sync, crc check and verdict
module mrt_frame_ctrl #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_vld_i,
  input  mrt_pkg::in_item_t item_i,
  input  logic              tx_free_i,
  output logic              advance_o,
  output mrt_pkg::tx_load_t load_o
);

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 2);
  localparam logic [CNT_W-1:0] BUF_CNT = CNT_W'(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] OVF_CNT = CNT_W'(BUFFER_BYTES + 1);

  logic             waiting_q, waiting_d;
  logic [7:0]       exp_addr_q, exp_addr_d;
  logic             attempt_q, attempt_d;
  logic             seen_q, seen_d;
  logic             synced_q, synced_d;
  logic [15:0]      crc_q, crc_d;
  logic [CNT_W-1:0] kept_q, kept_d;
  logic [7:0]       func_q, func_d;
  logic [7:0]       len_q, len_d;
  logic [15:0]      value_q, value_d;
  logic             needs_out;
  mrt_pkg::status_e verdict;

  // verdict of the current chunk, in priority order
  always_comb begin
    priority if (!seen_q) begin
      verdict = mrt_pkg::STATUS_TIMEOUT;
    end else if (!synced_q) begin
      verdict = mrt_pkg::STATUS_FRAME_ERR;
    end else if (crc_q != 16'h0000) begin
      verdict = mrt_pkg::STATUS_FRAME_ERR;
    end else if (kept_q > BUF_CNT) begin
      verdict = mrt_pkg::STATUS_FRAME_ERR;
    end else if (func_q[mrt_pkg::EXC_BIT]) begin
      verdict = mrt_pkg::STATUS_EXCEPTION;
    end else if (10'(kept_q) != mrt_pkg::FRAME_OVERHEAD + 10'(len_q)) begin
      verdict = mrt_pkg::STATUS_FRAME_ERR;
    end else begin
      verdict = mrt_pkg::STATUS_OK;
    end
  end

  // next state for the transaction held in the input register
  always_comb begin
    waiting_d  = waiting_q;
    exp_addr_d = exp_addr_q;
    attempt_d  = attempt_q;
    seen_d     = seen_q;
    synced_d   = synced_q;
    crc_d      = crc_q;
    kept_d     = kept_q;
    func_d     = func_q;
    len_d      = len_q;
    value_d    = value_q;
    needs_out  = 1'b0;

    if (item_i.opcode == mrt_pkg::OP_SEND_REQ) begin
      needs_out  = 1'b1;
      waiting_d  = 1'b1;
      exp_addr_d = item_i.dev_addr;
      attempt_d  = 1'b0;
      seen_d     = 1'b0;
      synced_d   = 1'b0;
      crc_d      = mrt_pkg::CRC_INIT;
      kept_d     = '0;
      func_d     = 8'h00;
      len_d      = 8'h00;
      value_d    = 16'h0000;
    end else if (waiting_q && item_i.opcode == mrt_pkg::OP_RX_BYTE) begin
      seen_d = 1'b1;
      if (synced_q || item_i.rx_byte == exp_addr_q) begin
        synced_d = 1'b1;
        if (kept_q >= BUF_CNT) begin
          kept_d = OVF_CNT;
        end else begin
          unique case (kept_q)
            CNT_W'(1): func_d = item_i.rx_byte;
            CNT_W'(2): len_d = item_i.rx_byte;
            CNT_W'(3): value_d = {item_i.rx_byte, value_q[7:0]};
            CNT_W'(4): value_d = {value_q[15:8], item_i.rx_byte};
            default: ;
          endcase
          crc_d  = mrt_pkg::crc_byte(crc_q, item_i.rx_byte);
          kept_d = kept_q + CNT_W'(1);
        end
      end
    end else if (waiting_q && item_i.opcode == mrt_pkg::OP_SILENCE) begin
      // chunk with bytes but no address gets one retry
      needs_out = !(seen_q && !synced_q && !attempt_q);
      waiting_d = !needs_out;
      attempt_d = !needs_out;
      seen_d    = 1'b0;
      synced_d  = 1'b0;
      crc_d     = mrt_pkg::CRC_INIT;
      kept_d    = '0;
      func_d    = 8'h00;
      len_d     = 8'h00;
      value_d   = 16'h0000;
    end
  end

  // handshake with the serializer and its load request
  always_comb begin
    advance_o         = item_vld_i && (!needs_out || tx_free_i);
    load_o.req        = advance_o && needs_out;
    load_o.verdict    = (item_i.opcode != mrt_pkg::OP_SEND_REQ);
    load_o.dev_addr   = item_i.dev_addr;
    load_o.reg_addr   = item_i.reg_addr;
    load_o.status     = verdict;
    load_o.reg_value  = (verdict == mrt_pkg::STATUS_OK) ? value_q : 16'h0000;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q  <= 1'b0;
      exp_addr_q <= 8'h00;
      attempt_q  <= 1'b0;
      seen_q     <= 1'b0;
      synced_q   <= 1'b0;
      crc_q      <= mrt_pkg::CRC_INIT;
      kept_q     <= '0;
      func_q     <= 8'h00;
      len_q      <= 8'h00;
      value_q    <= 16'h0000;
    end else if (advance_o) begin
      waiting_q  <= waiting_d;
      exp_addr_q <= exp_addr_d;
      attempt_q  <= attempt_d;
      seen_q     <= seen_d;
      synced_q   <= synced_d;
      crc_q      <= crc_d;
      kept_q     <= kept_d;
      func_q     <= func_d;
      len_q      <= len_d;
      value_q    <= value_d;
    end
  end

endmodule

>>> rtl/core/mrt_tx_serializer.sv
// output serializer: request bytes with running crc, or a single verdict
module mrt_tx_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mrt_pkg::tx_load_t  load_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mrt_pkg::out_item_t out_o
);

  logic             busy_q;
  logic             verdict_q;
  logic [2:0]       idx_q;
  logic [7:0]       addr_q;
  logic [15:0]      reg_q;
  logic [15:0]      crc_q;
  mrt_pkg::status_e status_q;
  logic [15:0]      value_q;
  logic [7:0]       cur_byte;
  logic             is_last;
  logic             done;

  // byte of the request frame at the current position
  always_comb begin
    unique case (idx_q)
      3'd0: cur_byte = addr_q;
      3'd1: cur_byte = mrt_pkg::FUNC_READ_HOLDING;
      3'd2: cur_byte = reg_q[15:8];
      3'd3: cur_byte = reg_q[7:0];
      3'd4: cur_byte = mrt_pkg::READ_COUNT[15:8];
      3'd5: cur_byte = mrt_pkg::READ_COUNT[7:0];
      3'd6: cur_byte = crc_q[7:0];
      3'd7: cur_byte = crc_q[15:8];
      default: cur_byte = 8'h00;
    endcase
  end

  // output payload and handshake
  always_comb begin
    is_last          = verdict_q || (idx_q == 3'(mrt_pkg::REQ_BYTES - 1));
    done             = busy_q && out_ready_i && is_last;
    free_o           = !busy_q || (out_ready_i && is_last);
    out_valid_o      = busy_q;
    out_o.kind       = verdict_q ? mrt_pkg::KIND_VERDICT : mrt_pkg::KIND_TX;
    out_o.tx_byte    = verdict_q ? 8'h00 : cur_byte;
    out_o.status     = verdict_q ? status_q : mrt_pkg::STATUS_OK;
    out_o.reg_value  = verdict_q ? value_q : 16'h0000;
    out_o.last       = is_last;
  end

  // control: busy flag, kind and byte position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      verdict_q <= 1'b0;
      idx_q     <= 3'd0;
    end else if (load_i.req) begin
      busy_q    <= 1'b1;
      verdict_q <= load_i.verdict;
      idx_q     <= 3'd0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (busy_q && out_ready_i) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  // payload and crc over the bytes sent so far
  always_ff @(posedge clk_i) begin
    if (load_i.req) begin
      addr_q   <= load_i.dev_addr;
      reg_q    <= load_i.reg_addr;
      status_q <= load_i.status;
      value_q  <= load_i.reg_value;
      crc_q    <= mrt_pkg::CRC_INIT;
    end else if (busy_q && out_ready_i && !verdict_q &&
                 (idx_q < 3'(mrt_pkg::REQ_CRC_POS))) begin
      crc_q <= mrt_pkg::crc_byte(crc_q, cur_byte);
    end
  end

endmodule

>>> rtl/core/modbus_rtu_read_transaction.sv
// top level of the modbus rtu single holding register read master
// A transaction enters an input register and is handled from there.
// Received bytes, silences that start a retry and ignored transactions
// can follow one another every cycle, even while results are still waiting
// at the output. A read request puts out eight bytes, one per cycle that the
// output accepts, with the request crc computed byte by byte as they leave;
// a silence that ends the reply gives one verdict transaction. The output
// serializer holds one request or one verdict, so a request or verdict waits
// in the input register until the previous one has fully drained.
`include "assert_macros.svh"

module modbus_rtu_read_transaction #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mrt_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mrt_pkg::out_item_t out_o
);

  logic              in_vld_q;
  mrt_pkg::in_item_t in_q;
  logic              advance;
  logic              tx_free;
  mrt_pkg::tx_load_t load;

  // input register
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  // protocol handling
  mrt_frame_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_frame_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_vld_i(in_vld_q),
    .item_i    (in_q),
    .tx_free_i (tx_free),
    .advance_o (advance),
    .load_o    (load)
  );

  // result output
  mrt_tx_serializer u_tx_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .free_o     (tx_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // checks
  `MRT_ASSERT_NEVER(a_load_when_free, clk_i, rst_ni, load.req && !tx_free)
  `MRT_ASSERT_NEVER(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o && !in_vld_q)
  `MRT_ASSERT(a_drain_after_last, clk_i, rst_ni, out_valid_o && out_ready_i && out_o.last && !load.req |=> !out_valid_o)
  `MRT_ASSERT_NEVER(a_verdict_is_last, clk_i, rst_ni, out_valid_o && out_o.kind && !out_o.last)

endmodule
